[sv/cas_pkg.sv]
// ----------------------------------------------------------------------------
// cas_pkg
// Shared types and constants for the automaton row step block.
// ----------------------------------------------------------------------------
`default_nettype none

package cas_pkg;

  localparam int CellW = 24;

  // operating modes
  localparam logic [1:0] MODE_PLAIN = 2'd0;
  localparam logic [1:0] MODE_SPLIT = 2'd1;
  localparam logic [1:0] MODE_DIR   = 2'd2;

  // register indexes
  localparam logic [2:0] REG_MODE      = 3'd0;
  localparam logic [2:0] REG_ROW_WIDTH = 3'd1;
  localparam logic [2:0] REG_RULE_ZERO = 3'd2;
  localparam logic [2:0] REG_RULE_ONE  = 3'd3;
  localparam logic [2:0] REG_RULE_TWO  = 3'd4;
  localparam logic [2:0] REG_ON_VALUE  = 3'd5;
  localparam logic [2:0] REG_OFF_VALUE = 3'd6;
  localparam logic [2:0] REG_HALF_VAL  = 3'd7;

  // reset values
  localparam logic [12:0] RST_ROW_WIDTH = 13'd64;
  localparam logic [7:0]  RST_RULE      = 8'h5a;
  localparam logic [7:0]  RST_ON        = 8'hff;
  localparam logic [7:0]  RST_OFF       = 8'h00;
  localparam logic [7:0]  RST_HALF      = 8'h45;

  // result slots of a job
  localparam logic [1:0] SLOT_PREV = 2'd0;
  localparam logic [1:0] SLOT_LAST = 2'd1;
  localparam logic [1:0] SLOT_WRAP = 2'd2;

  typedef struct packed {
    logic [7:0] chan_c_in;
    logic [7:0] chan_b_in;
    logic [7:0] chan_a_in;
  } src_item_t;

  typedef struct packed {
    logic [11:0] cell_index;
    logic [7:0]  chan_a_out;
    logic [7:0]  chan_b_out;
    logic [7:0]  chan_c_out;
    logic        write_enable;
    logic        row_done;
  } res_item_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [12:0] row_width;
    logic [7:0]  rule_zero;
    logic [7:0]  rule_one;
    logic [7:0]  rule_two;
    logic [7:0]  on_value;
    logic [7:0]  off_value;
    logic [7:0]  half_value;
  } cfg_t;

  // one accepted cell with the context needed for its results
  typedef struct packed {
    logic             multi;
    logic [11:0]      idx;
    logic [CellW-1:0] older;
    logic [CellW-1:0] newer;
    logic [CellW-1:0] cur;
    logic [CellW-1:0] first;
    logic [CellW-1:0] second;
  } job_t;

  // neighborhood of one result
  typedef struct packed {
    logic [CellW-1:0] left;
    logic [CellW-1:0] mid;
    logic [CellW-1:0] right;
    logic [11:0]      idx;
    logic             done;
  } window_t;

endpackage

`default_nettype wire

[sv/cas_regs.sv]
// ----------------------------------------------------------------------------
// cas_regs
// Configuration register file behind a simple APB-style port.
// ----------------------------------------------------------------------------
`default_nettype none

module cas_regs import cas_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  reg_sel,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output cfg_t             cfg
);

  logic wr;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode       <= MODE_PLAIN;
      cfg.row_width  <= RST_ROW_WIDTH;
      cfg.rule_zero  <= RST_RULE;
      cfg.rule_one   <= RST_RULE;
      cfg.rule_two   <= RST_RULE;
      cfg.on_value   <= RST_ON;
      cfg.off_value  <= RST_OFF;
      cfg.half_value <= RST_HALF;
    end else if (wr) begin
      unique case (reg_sel)
        REG_MODE:      cfg.mode       <= pwdata[1:0];
        REG_ROW_WIDTH: cfg.row_width  <= pwdata[12:0];
        REG_RULE_ZERO: cfg.rule_zero  <= pwdata[7:0];
        REG_RULE_ONE:  cfg.rule_one   <= pwdata[7:0];
        REG_RULE_TWO:  cfg.rule_two   <= pwdata[7:0];
        REG_ON_VALUE:  cfg.on_value   <= pwdata[7:0];
        REG_OFF_VALUE: cfg.off_value  <= pwdata[7:0];
        REG_HALF_VAL:  cfg.half_value <= pwdata[7:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_MODE:      prdata = {30'd0, cfg.mode};
      REG_ROW_WIDTH: prdata = {19'd0, cfg.row_width};
      REG_RULE_ZERO: prdata = {24'd0, cfg.rule_zero};
      REG_RULE_ONE:  prdata = {24'd0, cfg.rule_one};
      REG_RULE_TWO:  prdata = {24'd0, cfg.rule_two};
      REG_ON_VALUE:  prdata = {24'd0, cfg.on_value};
      REG_OFF_VALUE: prdata = {24'd0, cfg.off_value};
      REG_HALF_VAL:  prdata = {24'd0, cfg.half_value};
      default:       prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

[sv/cas_window.sv]
// ----------------------------------------------------------------------------
// cas_window
// Row position tracking and neighbor history; forms a job per cell from cell 2 on.
// ----------------------------------------------------------------------------
`default_nettype none

module cas_window import cas_pkg::*; #(
  parameter int MAX_WIDTH = 4096
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [12:0]      row_width,
  input  wire logic             take,
  input  wire logic [CellW-1:0] pixel,
  output logic                  job_load,
  output job_t                  job_next
);

  localparam int CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int WN = $clog2(MAX_WIDTH + 1);
  localparam int WW = (WN > 13) ? WN : 13;

  logic [CW-1:0]    counter;
  logic [CellW-1:0] first_cell;
  logic [CellW-1:0] second_cell;
  logic [CellW-1:0] older_cell;
  logic [CellW-1:0] newer_cell;
  logic [WW-1:0]    width_raw;
  logic [WW-1:0]    width_lim;
  logic             at_start;
  logic             at_second;
  logic             row_end;

  always_comb begin
    width_raw = WW'(row_width);
    priority if (width_raw < WW'(3)) begin
      width_lim = WW'(3);
    end else if (width_raw > WW'(MAX_WIDTH)) begin
      width_lim = WW'(MAX_WIDTH);
    end else begin
      width_lim = width_raw;
    end
  end

  assign at_start  = (counter == '0);
  assign at_second = (counter == CW'(1));
  assign row_end   = WW'(counter) >= (width_lim - WW'(1));
  assign job_load  = take && !at_start && !at_second;

  always_comb begin
    job_next.multi  = row_end;
    job_next.idx    = 12'(counter - CW'(1));
    job_next.older  = older_cell;
    job_next.newer  = newer_cell;
    job_next.cur    = pixel;
    job_next.first  = first_cell;
    job_next.second = second_cell;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      counter     <= '0;
      first_cell  <= '0;
      second_cell <= '0;
      older_cell  <= '0;
      newer_cell  <= '0;
    end else if (take) begin
      priority if (at_start) begin
        first_cell <= pixel;
        newer_cell <= pixel;
        counter    <= CW'(1);
      end else if (at_second) begin
        second_cell <= pixel;
        older_cell  <= newer_cell;
        newer_cell  <= pixel;
        counter     <= CW'(2);
      end else if (row_end) begin
        counter <= '0;
      end else begin
        older_cell <= newer_cell;
        newer_cell <= pixel;
        counter    <= counter + CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

[sv/cas_eval.sv]
// ----------------------------------------------------------------------------
// cas_eval
// Applies the automaton rule to one neighborhood and forms a result item.
// ----------------------------------------------------------------------------
`default_nettype none

module cas_eval import cas_pkg::*; (
  input  wire cfg_t    cfg,
  input  wire window_t win,
  output res_item_t    res
);

  function automatic logic rule_bit(logic [7:0] rule, logic l, logic m, logic r);
    return rule[{l, m, r}];
  endfunction

  function automatic logic any_set(logic [CellW-1:0] c, logic [7:0] off);
    return (c[7:0] != off) || (c[15:8] != off) || (c[23:16] != off);
  endfunction

  logic ls, ms, rs;
  logic fill_a, fill_b, fill_c;
  logic fill_dir, fill_plain;

  always_comb begin
    ls = any_set(win.left, cfg.off_value);
    ms = any_set(win.mid, cfg.off_value);
    rs = any_set(win.right, cfg.off_value);
    fill_dir = rule_bit(cfg.rule_zero, ls, ms, rs);
    fill_a = rule_bit(cfg.rule_zero, win.left[7:0] == cfg.on_value,
                      win.mid[7:0] == cfg.on_value, win.right[7:0] == cfg.on_value);
    fill_b = rule_bit(cfg.rule_one, win.left[15:8] == cfg.on_value,
                      win.mid[15:8] == cfg.on_value, win.right[15:8] == cfg.on_value);
    fill_c = rule_bit(cfg.rule_two, win.left[23:16] == cfg.on_value,
                      win.mid[23:16] == cfg.on_value, win.right[23:16] == cfg.on_value);
    // plain mode looks at channel 0 with rule zero, same as split channel 0
    fill_plain = fill_a;

    res.cell_index = win.idx;
    res.row_done   = win.done;
    unique case (cfg.mode)
      MODE_SPLIT: begin
        res.chan_a_out   = fill_a ? cfg.on_value : cfg.off_value;
        res.chan_b_out   = fill_b ? cfg.on_value : cfg.off_value;
        res.chan_c_out   = fill_c ? cfg.on_value : cfg.off_value;
        res.write_enable = 1'b1;
      end
      MODE_DIR: begin
        res.chan_a_out   = !fill_dir ? 8'd0 : (ls ? cfg.on_value : cfg.half_value);
        res.chan_b_out   = !fill_dir ? 8'd0 : (ms ? cfg.on_value : cfg.half_value);
        res.chan_c_out   = !fill_dir ? 8'd0 : (rs ? cfg.on_value : cfg.half_value);
        res.write_enable = fill_dir;
      end
      default: begin
        res.chan_a_out   = fill_plain ? cfg.on_value : 8'd0;
        res.chan_b_out   = fill_plain ? cfg.on_value : 8'd0;
        res.chan_c_out   = fill_plain ? cfg.on_value : 8'd0;
        res.write_enable = fill_plain;
      end
    endcase
  end

endmodule

`default_nettype wire

[sv/cellular_automaton_row_step.sv]
// ----------------------------------------------------------------------------
// cellular_automaton_row_step
// Streams one row of pixels through an elementary automaton rule.
// ----------------------------------------------------------------------------
// Cells of a row enter in order, one item per cycle unless src_ready holds
// them back, and the next generation leaves as result items. Cells 0 and 1
// give no result; every later cell gives the result for the cell before it,
// through the job register and then the output register, and the last cell
// of the row gives three results (itself minus one, itself, then cell 0
// flagged with row_done). No item is taken while the result sequencer works
// through the extra results of the row's last cell. The output register lets
// a new item be taken while a finished result waits for res_ready. Row width
// is clamped to 3..MAX_WIDTH; register writes belong between rows.
`default_nettype none

module cellular_automaton_row_step import cas_pkg::*; #(
  parameter int MAX_WIDTH = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // cell stream in
  input  wire logic        src_valid,
  output logic             src_ready,
  input  wire src_item_t   src_item,
  // result stream out
  output logic             res_valid,
  input  wire logic        res_ready,
  output res_item_t        res_item,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  cfg_t             cfg;
  logic             src_take;
  logic             job_load;
  job_t             job_next;
  job_t             job;
  logic             job_valid;
  logic [1:0]       slot;
  logic             job_last;
  logic             adv;
  window_t          win;
  res_item_t        res_calc;
  logic [CellW-1:0] src_cell;

  assign pready = 1'b1;

  cas_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .reg_sel (paddr[4:2]),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  // channel 0 sits in the low byte of a packed cell
  assign src_cell = {src_item.chan_c_in, src_item.chan_b_in, src_item.chan_a_in};
  assign src_take = src_valid && src_ready;

  cas_window #(.MAX_WIDTH(MAX_WIDTH)) u_window (
    .clk       (clk),
    .rst       (rst),
    .row_width (cfg.row_width),
    .take      (src_take),
    .pixel     (src_cell),
    .job_load  (job_load),
    .job_next  (job_next)
  );

  // job register advances one result per cycle when the output slot frees up
  assign adv      = job_valid && (!res_valid || res_ready);
  assign job_last = !job.multi || (slot == SLOT_WRAP);
  // taking a new cell needs the job register empty or draining its last result
  assign src_ready = !job_valid || (adv && job_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      slot      <= SLOT_PREV;
    end else begin
      if (adv) begin
        slot <= job_last ? SLOT_PREV : slot + 2'd1;
      end
      if (job_load) begin
        job_valid <= 1'b1;
      end else if (adv && job_last) begin
        job_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_load) begin
      job <= job_next;
    end
  end

  // pick the neighborhood for the current slot of the job
  always_comb begin
    unique case (slot)
      SLOT_LAST: begin
        win.left  = job.newer;
        win.mid   = job.cur;
        win.right = job.first;
        win.idx   = job.idx + 12'd1;
        win.done  = 1'b0;
      end
      SLOT_WRAP: begin
        win.left  = job.cur;
        win.mid   = job.first;
        win.right = job.second;
        win.idx   = 12'd0;
        win.done  = 1'b1;
      end
      default: begin
        win.left  = job.older;
        win.mid   = job.newer;
        win.right = job.cur;
        win.idx   = job.idx;
        win.done  = 1'b0;
      end
    endcase
  end

  cas_eval u_eval (
    .cfg (cfg),
    .win (win),
    .res (res_calc)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_item <= res_calc;
    end
  end

`ifndef SYNTHESIS
  a_slot_needs_multi: assert property (@(posedge clk) disable iff (rst)
    (slot != SLOT_PREV) |-> (job_valid && job.multi))
    else $error("slot past first result without a row-end job");

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    slot != 2'd3)
    else $error("result slot out of range");

  a_done_is_cell_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_item.row_done) |-> (res_item.cell_index == 12'd0))
    else $error("row_done on a cell other than cell 0");

  a_slot_rewinds: assert property (@(posedge clk) disable iff (rst)
    (adv && job_last) |=> (slot == SLOT_PREV))
    else $error("slot did not rewind after the last result of a job");

  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    (job_load) |-> (!job_valid || (adv && job_last)))
    else $error("job overwritten before all its results left");
`endif

endmodule

`default_nettype wire
